// ===== rtl/core/p2ba_pkg.sv =====
package p2ba_pkg;

  localparam int POOL_PAGES_DEF = 16;
  localparam int PAGE_BYTES    = 4096;
  localparam int REQ_W         = 17;
  localparam int OFF_W         = 16;
  localparam int GRANT_W       = 16;
  localparam int STAT_W        = 2;
  localparam int BKT_W         = 3;
  localparam int BUCKETS       = 8;
  localparam int SUB_W         = 7;    // 32-byte slots in a page, as index bits
  localparam int PGOFF_W       = 12;
  localparam int NRUN_W        = 6;
  localparam int INFO_W        = REQ_W + 1;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 24;

  localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_IGN = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_TAKE_RD,
    OP_TAKE_WR,
    OP_SPLIT,
    OP_POP_RD,
    OP_POP_WR,
    OP_RUN_RD,
    OP_RUN_CHK,
    OP_RUN_CLR,
    OP_FREE_RD,
    OP_FREE_CHK,
    OP_REL_CLR,
    OP_INS_RD,
    OP_INS_CHK,
    OP_INS_LINK,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic                set_code;
    logic [STAT_W-1:0]   code;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic clr_last;
    logic kind_free;
    logic page_bad;
    logic alloc_zero;
    logic alloc_small;
    logic bkt_empty;
    logic fph_empty;
    logic run_too_long;
    logic split_last;
    logic run_full;
    logic run_ext;
    logic run_next_zero;
    logic fr_small;
    logic fr_run;
    logic ins_head;
    logic ins_adv;
    logic cnt_last;
  } dp_stat_t;

  // Bucket of a size of at most 4096 bytes: 32 bytes and less is bucket 0.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [12:0] sz);
    logic [BKT_W-1:0] b;
    b = '0;
    for (int k = 0; k < BUCKETS - 1; k++) begin
      if (sz > 13'(32 << k)) begin
        b = BKT_W'(k + 1);
      end
    end
    return b;
  endfunction

  // Pages needed for a byte count, rounded up.
  function automatic logic [NRUN_W-1:0] nrun(input logic [REQ_W-1:0] v);
    logic [REQ_W:0] s;
    s = {1'b0, v} + (REQ_W + 1)'(PAGE_BYTES - 1);
    return NRUN_W'(s >> PGOFF_W);
  endfunction

endpackage

// ===== rtl/core/p2ba_ram.sv =====
module p2ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/p2ba_ctrl.sv =====
module p2ba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  p2ba_pkg::dp_stat_t st,
  output p2ba_pkg::ctl_cmd_t cmd
);

  typedef enum logic [17:0] {
    S_CLEAR    = 18'b000000000000000001,
    S_IDLE     = 18'b000000000000000010,
    S_DECODE   = 18'b000000000000000100,
    S_TAKE_RD  = 18'b000000000000001000,
    S_TAKE_WR  = 18'b000000000000010000,
    S_SPLIT    = 18'b000000000000100000,
    S_POP_RD   = 18'b000000000001000000,
    S_POP_WR   = 18'b000000000010000000,
    S_RUN_RD   = 18'b000000000100000000,
    S_RUN_CHK  = 18'b000000001000000000,
    S_RUN_CLR  = 18'b000000010000000000,
    S_FREE_RD  = 18'b000000100000000000,
    S_FREE_CHK = 18'b000001000000000000,
    S_REL_CLR  = 18'b000010000000000000,
    S_INS_RD   = 18'b000100000000000000,
    S_INS_CHK  = 18'b001000000000000000,
    S_INS_LINK = 18'b010000000000000000,
    S_DONE     = 18'b100000000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.op       = p2ba_pkg::OP_NONE;
    cmd.set_code = 1'b0;
    cmd.code     = p2ba_pkg::STAT_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.op = p2ba_pkg::OP_CLEAR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = p2ba_pkg::OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = p2ba_pkg::OP_DECODE;
        if (st.kind_free) begin
          if (st.page_bad) begin
            cmd.set_code = 1'b1;
            cmd.code     = p2ba_pkg::STAT_IGN;
            state_next   = S_DONE;
          end else begin
            state_next = S_FREE_RD;
          end
        end else if (st.alloc_zero) begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_IGN;
          state_next   = S_DONE;
        end else if (st.alloc_small) begin
          if (!st.bkt_empty) begin
            state_next = S_POP_RD;
          end else if (st.fph_empty) begin
            cmd.set_code = 1'b1;
            cmd.code     = p2ba_pkg::STAT_OOM;
            state_next   = S_DONE;
          end else begin
            state_next = S_TAKE_RD;
          end
        end else if (st.run_too_long || st.fph_empty) begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_OOM;
          state_next   = S_DONE;
        end else begin
          state_next = S_RUN_RD;
        end
      end
      S_TAKE_RD: begin
        cmd.op     = p2ba_pkg::OP_TAKE_RD;
        state_next = S_TAKE_WR;
      end
      S_TAKE_WR: begin
        cmd.op     = p2ba_pkg::OP_TAKE_WR;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.op = p2ba_pkg::OP_SPLIT;
        if (st.split_last) state_next = S_POP_RD;
      end
      S_POP_RD: begin
        cmd.op     = p2ba_pkg::OP_POP_RD;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.op       = p2ba_pkg::OP_POP_WR;
        cmd.set_code = 1'b1;
        cmd.code     = p2ba_pkg::STAT_OK;
        state_next   = S_DONE;
      end
      S_RUN_RD: begin
        cmd.op     = p2ba_pkg::OP_RUN_RD;
        state_next = S_RUN_CHK;
      end
      S_RUN_CHK: begin
        cmd.op = p2ba_pkg::OP_RUN_CHK;
        if (st.run_full) begin
          state_next = S_RUN_CLR;
        end else if (st.run_ext) begin
          state_next = S_RUN_RD;
        end else if (st.run_next_zero) begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_OOM;
          state_next   = S_DONE;
        end else begin
          state_next = S_RUN_RD;
        end
      end
      S_RUN_CLR: begin
        cmd.op = p2ba_pkg::OP_RUN_CLR;
        if (st.cnt_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_OK;
          state_next   = S_DONE;
        end
      end
      S_FREE_RD: begin
        cmd.op     = p2ba_pkg::OP_FREE_RD;
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.op = p2ba_pkg::OP_FREE_CHK;
        if (st.fr_small) begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_OK;
          state_next   = S_DONE;
        end else if (st.fr_run) begin
          state_next = S_REL_CLR;
        end else begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_IGN;
          state_next   = S_DONE;
        end
      end
      S_REL_CLR: begin
        cmd.op = p2ba_pkg::OP_REL_CLR;
        if (!st.ins_head) begin
          state_next = S_INS_RD;
        end else if (st.cnt_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_OK;
          state_next   = S_DONE;
        end
      end
      S_INS_RD: begin
        cmd.op     = p2ba_pkg::OP_INS_RD;
        state_next = S_INS_CHK;
      end
      S_INS_CHK: begin
        cmd.op     = p2ba_pkg::OP_INS_CHK;
        state_next = st.ins_adv ? S_INS_RD : S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd.op = p2ba_pkg::OP_INS_LINK;
        if (st.cnt_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = p2ba_pkg::STAT_OK;
          state_next   = S_DONE;
        end else begin
          state_next = S_REL_CLR;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op     = p2ba_pkg::OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/p2ba_dpath.sv =====
module p2ba_dpath #(
  parameter int POOL_PAGES = p2ba_pkg::POOL_PAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  p2ba_pkg::ctl_cmd_t                  cmd,
  output p2ba_pkg::dp_stat_t                  st,
  input  logic                                in_kind,
  input  logic [p2ba_pkg::IN_DATA_W-1:0]      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [p2ba_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int PIW  = $clog2(POOL_PAGES);
  localparam int PW   = PIW + 1;
  localparam int CW   = PIW + 1;
  localparam int SIW  = PIW + p2ba_pkg::SUB_W;
  localparam int SLW  = SIW + 1;
  localparam int XW   = PIW + 8;
  localparam int NSLT = POOL_PAGES << p2ba_pkg::SUB_W;
  localparam int RW   = p2ba_pkg::REQ_W;
  localparam int BW   = p2ba_pkg::BKT_W;
  localparam int SBW  = p2ba_pkg::SUB_W;

  // list links hold index plus one, zero ends a list
  logic [SLW-1:0]               heads [p2ba_pkg::BUCKETS];
  logic [PW-1:0]                fph;
  logic [PIW-1:0]               clr;
  logic                         kind;
  logic [RW-1:0]                size;
  logic [p2ba_pkg::OFF_W-1:0]   off;
  logic [p2ba_pkg::NRUN_W-1:0]  n;
  logic [PIW-1:0]               pg;
  logic [PIW-1:0]               start;
  logic [PIW-1:0]               walk;
  logic [PIW-1:0]               q;
  logic [PW-1:0]                prev;
  logic [PW-1:0]                firstl;
  logic [CW-1:0]                cnt;
  logic [SBW-1:0]               sidx;
  logic [SIW-1:0]               blk;
  logic [p2ba_pkg::GRANT_W-1:0] grant;
  logic [p2ba_pkg::STAT_W-1:0]  code;

  logic                         bwe;
  logic [SIW-1:0]               bwaddr, braddr;
  logic [SLW-1:0]               bwdata, brdata;
  logic                         lwe;
  logic [PIW-1:0]               lwaddr, lraddr;
  logic [PW-1:0]                lwdata, lrdata;
  logic                         iwe;
  logic [PIW-1:0]               iwaddr, iraddr;
  logic [p2ba_pkg::INFO_W-1:0]  iwdata, irdata;

  logic [BW-1:0]                bq, bf;
  logic [RW-1:0]                sz;
  logic [SBW:0]                 step;
  logic [SBW-1:0]               soff;
  logic [SIW-1:0]               slot, fidx, popidx;
  logic [SLW-1:0]               snext;
  logic [p2ba_pkg::PGOFF_W-1:0] msk, blk_off;
  logic [3:0]                   offp;
  logic [PW-1:0]                nextl;
  logic [PIW-1:0]               qrun;

  p2ba_ram #(.WIDTH(SLW), .DEPTH(NSLT)) u_blk (
    .clk(clk), .we(bwe), .waddr(bwaddr), .wdata(bwdata), .raddr(braddr), .rdata(brdata)
  );
  p2ba_ram #(.WIDTH(PW), .DEPTH(POOL_PAGES)) u_plink (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(lraddr), .rdata(lrdata)
  );
  p2ba_ram #(.WIDTH(p2ba_pkg::INFO_W), .DEPTH(POOL_PAGES)) u_pinfo (
    .clk(clk), .we(iwe), .waddr(iwaddr), .wdata(iwdata), .raddr(iraddr), .rdata(irdata)
  );

  assign bq      = p2ba_pkg::bucket_of(size[12:0]);
  assign sz      = irdata[RW-1:0];
  assign bf      = p2ba_pkg::bucket_of(sz[12:0]);
  assign step    = (SBW + 1)'(1) << bq;
  assign soff    = sidx << bq;
  assign slot    = {pg, soff};
  assign snext   = SLW'(slot) + SLW'(step) + SLW'(1);
  assign msk     = p2ba_pkg::PGOFF_W'(sz - RW'(1));
  assign blk_off = off[p2ba_pkg::PGOFF_W-1:0] & ~msk;
  assign fidx    = {pg, blk_off[p2ba_pkg::PGOFF_W-1:5]};
  assign popidx  = SIW'(heads[bq] - SLW'(1));
  assign offp    = off[p2ba_pkg::OFF_W-1:p2ba_pkg::PGOFF_W];
  assign nextl   = (walk == start) ? lrdata : firstl;
  assign qrun    = start + PIW'(cnt);

  always_comb begin
    st.out_free      = !out_valid || out_ready;
    st.clr_last      = (32'(clr) == POOL_PAGES - 1);
    st.kind_free     = kind;
    st.page_bad      = (32'(offp) >= POOL_PAGES);
    st.alloc_zero    = (size == '0);
    st.alloc_small   = (size <= RW'(p2ba_pkg::PAGE_BYTES));
    st.bkt_empty     = (heads[bq] == '0);
    st.fph_empty     = (fph == '0);
    st.run_too_long  = (32'(p2ba_pkg::nrun(size)) > POOL_PAGES);
    st.split_last    = ((SBW + 1)'(sidx) == ((SBW + 1)'(128) >> bq) - (SBW + 1)'(1));
    st.run_full      = (XW'(cnt) == XW'(n));
    st.run_ext       = (lrdata != '0) &&
                       (XW'(lrdata) == XW'(start) + XW'(cnt) + XW'(1));
    st.run_next_zero = (nextl == '0);
    st.fr_small      = (sz != '0) && (sz <= RW'(p2ba_pkg::PAGE_BYTES));
    st.fr_run        = irdata[RW];
    st.ins_head      = (fph == '0) || (XW'(fph) > XW'(q) + XW'(1));
    st.ins_adv       = (lrdata != '0) && (XW'(lrdata) <= XW'(q));
    st.cnt_last      = (XW'(cnt) == XW'(n) - XW'(1));
  end

  // memory ports
  always_comb begin
    bwe    = 1'b0;
    bwaddr = slot;
    bwdata = snext;
    braddr = popidx;
    lwe    = 1'b0;
    lwaddr = q;
    lwdata = '0;
    lraddr = walk;
    iwe    = 1'b0;
    iwaddr = q;
    iwdata = '0;
    iraddr = pg;
    case (cmd.op)
      p2ba_pkg::OP_CLEAR: begin
        lwe    = 1'b1;
        lwaddr = clr;
        lwdata = st.clr_last ? '0 : PW'(clr) + PW'(2);
        iwe    = 1'b1;
        iwaddr = clr;
      end
      p2ba_pkg::OP_TAKE_RD: begin
        lraddr = PIW'(fph - PW'(1));
      end
      p2ba_pkg::OP_TAKE_WR: begin
        lwe    = 1'b1;
        lwaddr = pg;
        iwe    = 1'b1;
        iwaddr = pg;
        iwdata = {1'b0, RW'(RW'(32) << bq)};
      end
      p2ba_pkg::OP_SPLIT: begin
        bwe    = 1'b1;
        bwdata = st.split_last ? heads[bq] : snext;
      end
      p2ba_pkg::OP_RUN_CHK: begin
        if (st.run_full && prev != '0) begin
          lwe    = 1'b1;
          lwaddr = PIW'(prev - PW'(1));
          lwdata = lrdata;
        end
      end
      p2ba_pkg::OP_RUN_CLR: begin
        lwe    = 1'b1;
        lwaddr = qrun;
        iwe    = 1'b1;
        iwaddr = qrun;
        iwdata = (cnt == '0) ? {1'b1, size} : '0;
      end
      p2ba_pkg::OP_FREE_CHK: begin
        if (st.fr_small) begin
          bwe    = 1'b1;
          bwaddr = fidx;
          bwdata = heads[bf];
        end
      end
      p2ba_pkg::OP_REL_CLR: begin
        iwe = 1'b1;
        if (st.ins_head) begin
          lwe    = 1'b1;
          lwdata = fph;
        end
      end
      p2ba_pkg::OP_INS_CHK: begin
        if (!st.ins_adv) begin
          lwe    = 1'b1;
          lwdata = lrdata;
        end
      end
      p2ba_pkg::OP_INS_LINK: begin
        lwe    = 1'b1;
        lwaddr = walk;
        lwdata = PW'(q) + PW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fph       <= PW'(1);
      clr       <= '0;
      for (int k = 0; k < p2ba_pkg::BUCKETS; k++) begin
        heads[k] <= '0;
      end
    end else begin
      // load the result register, hold it until taken
      if (cmd.op == p2ba_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
        out_data  <= {(p2ba_pkg::OUT_DATA_W - p2ba_pkg::GRANT_W - p2ba_pkg::STAT_W)'(0),
                      code, grant};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.set_code) code <= cmd.code;
      case (cmd.op)
        p2ba_pkg::OP_CLEAR: begin
          clr <= clr + PIW'(1);
        end
        p2ba_pkg::OP_LOAD: begin
          kind  <= in_kind;
          size  <= in_data[RW-1:0];
          off   <= in_data[RW +: p2ba_pkg::OFF_W];
          grant <= '0;
        end
        p2ba_pkg::OP_DECODE: begin
          pg    <= PIW'(offp);
          n     <= p2ba_pkg::nrun(size);
          prev  <= '0;
          start <= PIW'(fph - PW'(1));
          walk  <= PIW'(fph - PW'(1));
          cnt   <= CW'(1);
        end
        p2ba_pkg::OP_TAKE_RD: begin
          pg <= PIW'(fph - PW'(1));
        end
        p2ba_pkg::OP_TAKE_WR: begin
          fph  <= lrdata;
          sidx <= '0;
        end
        p2ba_pkg::OP_SPLIT: begin
          sidx <= sidx + SBW'(1);
          if (st.split_last) heads[bq] <= SLW'({pg, SBW'(0)}) + SLW'(1);
        end
        p2ba_pkg::OP_POP_RD: begin
          blk <= popidx;
        end
        p2ba_pkg::OP_POP_WR: begin
          heads[bq] <= brdata;
          grant     <= p2ba_pkg::GRANT_W'({blk, 5'b0});
        end
        p2ba_pkg::OP_RUN_CHK: begin
          if (walk == start) firstl <= lrdata;
          if (st.run_full) begin
            if (prev == '0) fph <= lrdata;
            cnt <= '0;
          end else if (st.run_ext) begin
            walk <= PIW'(lrdata - PW'(1));
            cnt  <= cnt + CW'(1);
          end else begin
            prev  <= PW'(start) + PW'(1);
            start <= PIW'(nextl - PW'(1));
            walk  <= PIW'(nextl - PW'(1));
            cnt   <= CW'(1);
          end
        end
        p2ba_pkg::OP_RUN_CLR: begin
          cnt   <= cnt + CW'(1);
          grant <= p2ba_pkg::GRANT_W'({start, 12'b0});
        end
        p2ba_pkg::OP_FREE_CHK: begin
          if (st.fr_small) begin
            heads[bf] <= SLW'(fidx) + SLW'(1);
          end else if (st.fr_run) begin
            n   <= p2ba_pkg::nrun(sz);
            q   <= pg;
            cnt <= '0;
          end
        end
        p2ba_pkg::OP_REL_CLR: begin
          if (st.ins_head) begin
            fph <= PW'(q) + PW'(1);
            cnt <= cnt + CW'(1);
            q   <= q + PIW'(1);
          end else begin
            walk <= PIW'(fph - PW'(1));
          end
        end
        p2ba_pkg::OP_INS_CHK: begin
          if (st.ins_adv) walk <= PIW'(lrdata - PW'(1));
        end
        p2ba_pkg::OP_INS_LINK: begin
          cnt <= cnt + CW'(1);
          q   <= q + PIW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/power_of_two_block_allocator.sv =====
// Channel   Fields (lowest bit first)                          Handshake
// s_axis    tuser: kind; tdata: request_bytes, release_offset  tvalid/tready
// m_axis    tdata: granted_offset, status                      tvalid/tready
//
// One transaction in flight. Alloc from a non-empty bucket decodes the request,
// reads the bucket head and pops it; an empty bucket first takes a page from
// the free page list and splits it into blocks of the bucket size.
// Large allocs walk the free page list, reading and checking each page link,
// then clear each page taken. Frees of a block push it onto its bucket; a run
// frees each page either at the list head or by a sorted insert that walks the
// free list. The page memories have one write port and one registered read port.
// After reset a clearing pass over every page rebuilds the page list.
// The result register lets a new input go in while the last result stalls.
module power_of_two_block_allocator #(
  parameter int POOL_PAGES = p2ba_pkg::POOL_PAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [p2ba_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // request_bytes, release_offset
  input  logic                               s_axis_tuser,  // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [p2ba_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // granted_offset, status
);

  p2ba_pkg::ctl_cmd_t cmd;
  p2ba_pkg::dp_stat_t st;

  p2ba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .st(st), .cmd(cmd)
  );

  p2ba_dpath #(.POOL_PAGES(POOL_PAGES)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .in_kind(s_axis_tuser), .in_data(s_axis_tdata),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

endmodule

// ===== rtl/core/p2ba_checker.sv =====
module p2ba_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [p2ba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3)
    else $error("undefined status code");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[17:16] != p2ba_pkg::STAT_OK |-> m_axis_tdata[15:0] == '0)
    else $error("offset given without a grant");

  a_clear_pass: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

endmodule

bind power_of_two_block_allocator p2ba_checker u_p2ba_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
